### rtl/stereogram_row_linker_core_macros.svh
// assertion macros shared by the row linker modules
`ifndef STEREOGRAM_ROW_LINKER_CORE_MACROS_SVH
`define STEREOGRAM_ROW_LINKER_CORE_MACROS_SVH

// same-cycle implication on the module clock, off during reset
`define SRL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the module clock, off during reset
`define SRL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/srl_pkg.sv
// shared types and constants of the stereogram row linker
`timescale 1ns / 1ps
`default_nettype none

package srl_pkg;

  // table geometry
  localparam int unsigned MaxRowWidth = 2048;
  localparam int unsigned PosW        = $clog2(MaxRowWidth);
  localparam int unsigned RowW        = 12;
  localparam int unsigned DepthW      = 17;
  localparam int unsigned SepW        = 12;
  localparam int unsigned ProdW       = DepthW + SepW;
  localparam int unsigned SumW        = ProdW + 1;
  localparam int unsigned SignedW     = PosW + 3;

  // fixed point constants
  localparam logic [DepthW-1:0] QOne      = DepthW'(65536);
  localparam logic [SumW-1:0]   RoundHalf = SumW'(32768);
  localparam logic [RowW-1:0]   RowMax    = RowW'(MaxRowWidth);

  // input action codes
  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_LINK    = 2'd1,
    ACT_RESOLVE = 2'd2,
    ACT_NOP     = 2'd3
  } act_e;

  // controller states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL,
    ST_SEP,
    ST_RANGE,
    ST_FIND_ISSUE,
    ST_FIND,
    ST_COMP_ISSUE,
    ST_COMP
  } state_e;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR_STEP,
    OP_MUL,
    OP_SEP,
    OP_RANGE,
    OP_FIND_ISSUE,
    OP_FIND,
    OP_COMP_ISSUE,
    OP_COMP
  } dp_op_e;

  // controller to datapath
  typedef struct packed {
    dp_op_e op;
    logic   side;      // 0 walks from left/position, 1 from right
    logic   save_a;    // keep the left root
    logic   link_wr;   // hang right root under left root
    logic   res_load;  // present a resolve beat
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic range_ok;
    logic found;
    logic comp_done;
  } dp_sts_t;

endpackage

`default_nettype wire

### rtl/srl_datapath.sv
// parent table, separation arithmetic and root walk registers
`timescale 1ns / 1ps
`default_nettype none
`include "stereogram_row_linker_core_macros.svh"

module srl_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire srl_pkg::dp_cmd_t              cmd_i,
  output srl_pkg::dp_sts_t                   sts_o,
  input  wire logic [srl_pkg::PosW-1:0]      position_i,
  input  wire logic [srl_pkg::DepthW-1:0]    depth_i,
  input  wire logic [srl_pkg::RowW-1:0]      row_width_i,
  input  wire logic [srl_pkg::SepW-1:0]      eye_sep_i,
  output logic                               done_o,
  output logic [srl_pkg::PosW-1:0]           root_position_o,
  output logic                               is_root_o
);

  localparam int unsigned PosW = srl_pkg::PosW;
  localparam int unsigned SW   = srl_pkg::SignedW;

  // parent table
  logic [PosW-1:0] mem_q [srl_pkg::MaxRowWidth];
  logic [PosW-1:0] rd_q;
  logic [PosW-1:0] raddr;
  logic            we;
  logic [PosW-1:0] waddr, wdata;

  // working registers
  logic [PosW-1:0]            clr_cnt_q;
  logic [PosW-1:0]            pos_q, left_q, right_q, cur_q, root_q, root_a_q;
  logic [srl_pkg::DepthW-1:0] q_q;
  logic [srl_pkg::ProdW-1:0]  prod_q;
  logic [srl_pkg::SepW-1:0]   sep_q;
  logic [PosW-1:0]            res_root_q;
  logic                       res_is_root_q;
  logic                       done_q;

  logic [PosW-1:0]            origin;
  logic [srl_pkg::SumW-1:0]   rnd;
  logic signed [SW-1:0]       left_s, right_s, width_s;
  logic [srl_pkg::RowW-1:0]   width_use;
  logic                       found, comp_done, roots_differ;

  assign origin       = cmd_i.side ? right_q : left_q;
  assign found        = (rd_q == cur_q);
  assign comp_done    = (cur_q == root_q);
  assign roots_differ = (root_a_q != root_q);

  // rounding of the q16 product
  assign rnd = srl_pkg::SumW'(prod_q) + srl_pkg::RoundHalf;

  // link columns and row bound check
  assign width_use = (row_width_i > srl_pkg::RowMax) ? srl_pkg::RowMax : row_width_i;
  assign left_s    = $signed(SW'(pos_q)) - $signed(SW'(sep_q[srl_pkg::SepW-1:1]));
  assign right_s   = left_s + $signed(SW'(sep_q));
  assign width_s   = $signed(SW'(width_use));

  assign sts_o.clr_last  = (clr_cnt_q == '1);
  assign sts_o.range_ok  = (sep_q != '0) && !left_s[SW-1] && (right_s < width_s);
  assign sts_o.found     = found;
  assign sts_o.comp_done = comp_done;

  // table port selection
  always_comb begin
    raddr = cur_q;
    we    = 1'b0;
    waddr = cur_q;
    wdata = root_q;
    case (cmd_i.op)
      srl_pkg::OP_CLEAR_STEP: begin
        we    = 1'b1;
        waddr = clr_cnt_q;
        wdata = clr_cnt_q;
      end
      srl_pkg::OP_FIND_ISSUE,
      srl_pkg::OP_COMP_ISSUE: begin
        raddr = origin;
      end
      srl_pkg::OP_FIND: begin
        raddr = rd_q;
      end
      srl_pkg::OP_COMP: begin
        raddr = rd_q;
        if (!comp_done) begin
          we = 1'b1;
        end else if (cmd_i.link_wr && roots_differ) begin
          we    = 1'b1;
          waddr = root_q;
          wdata = root_a_q;
        end
      end
      default: begin
        raddr = cur_q;
      end
    endcase
  end

  // table storage with registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  // sweep counter and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      if (cmd_i.op == srl_pkg::OP_CLEAR_STEP) begin
        clr_cnt_q <= clr_cnt_q + PosW'(1);
      end
      done_q <= cmd_i.res_load;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      srl_pkg::OP_LOAD: begin
        pos_q  <= position_i;
        left_q <= position_i;
        q_q    <= depth_i[srl_pkg::DepthW-1] ? '0 : srl_pkg::QOne - depth_i;
      end
      srl_pkg::OP_MUL: begin
        prod_q <= srl_pkg::ProdW'(q_q) * srl_pkg::ProdW'(eye_sep_i);
      end
      srl_pkg::OP_SEP: begin
        sep_q <= rnd[srl_pkg::SepW+15:16];
      end
      srl_pkg::OP_RANGE: begin
        left_q  <= left_s[PosW-1:0];
        right_q <= right_s[PosW-1:0];
      end
      srl_pkg::OP_FIND_ISSUE,
      srl_pkg::OP_COMP_ISSUE: begin
        cur_q <= origin;
      end
      srl_pkg::OP_FIND: begin
        if (found) begin
          root_q <= cur_q;
        end else begin
          cur_q <= rd_q;
        end
      end
      srl_pkg::OP_COMP: begin
        if (!comp_done) begin
          cur_q <= rd_q;
        end
      end
      default: begin
        cur_q <= cur_q;
      end
    endcase
    if (cmd_i.save_a) begin
      root_a_q <= root_q;
    end
    if (cmd_i.res_load) begin
      res_root_q    <= root_q;
      res_is_root_q <= (root_q == left_q);
    end
  end

  assign done_o          = done_q;
  assign root_position_o = res_root_q;
  assign is_root_o       = res_is_root_q;

  // result beat is a single-cycle strobe
  `SRL_ASSERT_NXT(a_done_single, done_q, !done_q, "result strobe held two cycles")
  // result beat only follows a finished compression walk
  `SRL_ASSERT_IMP(a_done_after_comp, done_q, $past(cmd_i.op == srl_pkg::OP_COMP),
                  "result strobe without a finished walk")

endmodule

`default_nettype wire

### rtl/srl_ctrl.sv
// sequencer for clear sweep, separation steps and root walks
`timescale 1ns / 1ps
`default_nettype none
`include "stereogram_row_linker_core_macros.svh"

module srl_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [1:0]       action_i,
  output logic                  busy,
  output srl_pkg::dp_cmd_t      cmd_o,
  input  wire srl_pkg::dp_sts_t sts_i
);

  srl_pkg::state_e state_q, state_d;
  logic            side_q, side_d;
  logic            link_q, link_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= srl_pkg::ST_CLEAR;
      side_q  <= 1'b0;
      link_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      side_q  <= side_d;
      link_q  <= link_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d        = state_q;
    side_d         = side_q;
    link_d         = link_q;
    busy           = 1'b1;
    cmd_o.op       = srl_pkg::OP_NONE;
    cmd_o.side     = side_q;
    cmd_o.save_a   = 1'b0;
    cmd_o.link_wr  = 1'b0;
    cmd_o.res_load = 1'b0;
    case (state_q)
      srl_pkg::ST_CLEAR: begin
        cmd_o.op = srl_pkg::OP_CLEAR_STEP;
        if (sts_i.clr_last) begin
          state_d = srl_pkg::ST_IDLE;
        end
      end
      srl_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          case (action_i)
            srl_pkg::ACT_CLEAR: begin
              state_d = srl_pkg::ST_CLEAR;
            end
            srl_pkg::ACT_LINK: begin
              cmd_o.op = srl_pkg::OP_LOAD;
              link_d   = 1'b1;
              side_d   = 1'b0;
              state_d  = srl_pkg::ST_MUL;
            end
            srl_pkg::ACT_RESOLVE: begin
              cmd_o.op = srl_pkg::OP_LOAD;
              link_d   = 1'b0;
              side_d   = 1'b0;
              state_d  = srl_pkg::ST_FIND_ISSUE;
            end
            default: begin
              state_d = srl_pkg::ST_IDLE;
            end
          endcase
        end
      end
      srl_pkg::ST_MUL: begin
        cmd_o.op = srl_pkg::OP_MUL;
        state_d  = srl_pkg::ST_SEP;
      end
      srl_pkg::ST_SEP: begin
        cmd_o.op = srl_pkg::OP_SEP;
        state_d  = srl_pkg::ST_RANGE;
      end
      srl_pkg::ST_RANGE: begin
        cmd_o.op = srl_pkg::OP_RANGE;
        state_d  = sts_i.range_ok ? srl_pkg::ST_FIND_ISSUE : srl_pkg::ST_IDLE;
      end
      srl_pkg::ST_FIND_ISSUE: begin
        cmd_o.op = srl_pkg::OP_FIND_ISSUE;
        state_d  = srl_pkg::ST_FIND;
      end
      srl_pkg::ST_FIND: begin
        cmd_o.op = srl_pkg::OP_FIND;
        if (sts_i.found) begin
          state_d = srl_pkg::ST_COMP_ISSUE;
        end
      end
      srl_pkg::ST_COMP_ISSUE: begin
        cmd_o.op = srl_pkg::OP_COMP_ISSUE;
        state_d  = srl_pkg::ST_COMP;
      end
      srl_pkg::ST_COMP: begin
        cmd_o.op = srl_pkg::OP_COMP;
        if (sts_i.comp_done) begin
          if (!link_q) begin
            cmd_o.res_load = 1'b1;
            state_d        = srl_pkg::ST_IDLE;
          end else if (!side_q) begin
            cmd_o.save_a = 1'b1;
            side_d       = 1'b1;
            state_d      = srl_pkg::ST_FIND_ISSUE;
          end else begin
            cmd_o.link_wr = 1'b1;
            state_d       = srl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = srl_pkg::ST_IDLE;
      end
    endcase
  end

  // a clear beat always starts a full sweep
  `SRL_ASSERT_NXT(a_clear_sweep, start && !busy && (action_i == srl_pkg::ACT_CLEAR),
                  state_q == srl_pkg::ST_CLEAR, "clear beat did not start the sweep")
  // the sweep ends back in idle
  `SRL_ASSERT_NXT(a_sweep_end, (state_q == srl_pkg::ST_CLEAR) && sts_i.clr_last,
                  state_q == srl_pkg::ST_IDLE && !busy, "sweep did not return to idle")
  // the right walk only runs for a link
  `SRL_ASSERT_IMP(a_side_link, side_q, link_q, "right-side walk outside a link")

endmodule

`default_nettype wire

### rtl/stereogram_row_linker_core.sv
// top level of the stereogram row linker: register port, sequencer and datapath
`timescale 1ns / 1ps
`default_nettype none

// Union-find row linker. A beat is taken when start is high and busy is low;
// busy stays high until the item is finished. After reset, and after every clear
// beat, the 2048-entry parent table is rewritten one entry per cycle with busy
// high. A link beat runs the separation multiply, rounding and range check, then
// two root walks if in range; a resolve beat takes one root walk. Each walk
// finds the root and compresses the path, bound by the table's single read port:
// one pointer hop per cycle. A resolve result is on root_position_o / is_root_o
// for exactly one cycle with done_o high and must be taken then; the receiver
// cannot stall it. Link and clear give no result. The configuration registers sit
// at byte address 0 (row_width) and 4 (eye_sep, the far-depth spacing); the user
// must write them only while busy is low; the block does not enforce it.
module stereogram_row_linker_core (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // item port
  input  wire logic                       start,
  output logic                            busy,
  input  wire logic [1:0]                 action_i,
  input  wire logic [srl_pkg::PosW-1:0]   position_i,
  input  wire logic [srl_pkg::DepthW-1:0] depth_i,
  // result port
  output logic                            done_o,
  output logic [srl_pkg::PosW-1:0]        root_position_o,
  output logic                            is_root_o,
  // configuration port
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [2:0]                 paddr,
  input  wire logic [31:0]                pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic [srl_pkg::RowW-1:0] row_width_q;
  logic [srl_pkg::SepW-1:0] eye_sep_q;
  logic                     cfg_wr;
  srl_pkg::dp_cmd_t         cmd;
  srl_pkg::dp_sts_t         sts;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q <= srl_pkg::RowW'(1200);
      eye_sep_q   <= srl_pkg::SepW'(256);
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        eye_sep_q <= pwdata[srl_pkg::SepW-1:0];
      end else begin
        row_width_q <= pwdata[srl_pkg::RowW-1:0];
      end
    end
  end

  // register read back
  assign prdata = paddr[2] ? 32'(eye_sep_q) : 32'(row_width_q);

  // sequencer
  srl_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .action_i (action_i),
    .busy     (busy),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // table and arithmetic
  srl_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .position_i      (position_i),
    .depth_i         (depth_i),
    .row_width_i     (row_width_q),
    .eye_sep_i       (eye_sep_q),
    .done_o          (done_o),
    .root_position_o (root_position_o),
    .is_root_o       (is_root_o)
  );

endmodule

`default_nettype wire
